// ===== sv/ksn_pkg.sv =====
// Shared types, codes and constants of the knob cursor navigator.
package ksn_pkg;

    // Default width of the stored timestamps.
    localparam int TIME_WIDTH_DEF = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_INDEX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_DIVISOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_ZONE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICK   = 3'd7;

    // Opcodes of an input transaction.
    localparam logic [1:0] OP_UPDATE   = 2'd0;
    localparam logic [1:0] OP_REANCHOR = 2'd1;
    localparam logic [1:0] OP_HOLD     = 2'd2;

    // Outcome of the first evaluation step of an item.
    localparam logic [1:0] EV_DONE   = 2'd0;
    localparam logic [1:0] EV_DWELL  = 2'd1;
    localparam logic [1:0] EV_TRAVEL = 2'd2;

    // Operand selection of the shared divider.
    localparam logic [1:0] DSEL_DWELL = 2'd0;
    localparam logic [1:0] DSEL_VEL   = 2'd1;
    localparam logic [1:0] DSEL_STEP  = 2'd2;

    // Quotient bits produced by the divider; every quotient used is below 128.
    localparam int QW = 7;

    typedef struct packed {
        logic       load;
        logic       eval;
        logic       dchk;
        logic       div_start;
        logic [1:0] div_sel;
        logic       dstep;
        logic       vel;
        logic       mul;
        logic       move;
        logic       out_load;
    } ksn_cmd_t;

    typedef struct packed {
        logic [1:0] eval_res;
        logic       dwell_go;
        logic       dwell_sat;
        logic       div_busy;
    } ksn_sts_t;

endpackage

// ===== sv/ksn_div.sv =====
// Shared restoring divider producing a seven-bit quotient, one bit per cycle.
module ksn_div
    import ksn_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [TIME_WIDTH-1:0] dividend,
    input  logic [15:0]           divisor,
    output logic                  busy,
    output logic [QW-1:0]         quot,
    output logic [QW-1:0]         rem_lo
);

    localparam int SW    = 16 + QW - 1;
    localparam int CW    = (TIME_WIDTH > SW + 1) ? TIME_WIDTH : SW + 1;
    localparam int CNT_W = $clog2(QW);

    logic [TIME_WIDTH-1:0] rem_reg;
    logic [SW-1:0]         dsh_reg;
    logic [QW-1:0]         q_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;

    logic [CW-1:0] rem_ext;
    logic [CW-1:0] dsh_ext;
    logic [CW-1:0] diff;
    logic          ge;

    assign rem_ext = CW'(rem_reg);
    assign dsh_ext = CW'(dsh_reg);
    assign ge      = rem_ext >= dsh_ext;
    assign diff    = rem_ext - dsh_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QW - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= {divisor, (QW - 1)'(0)};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= diff[TIME_WIDTH-1:0];
            end
            q_reg   <= {q_reg[QW-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign busy   = busy_reg;
    assign quot   = q_reg;
    assign rem_lo = rem_reg[QW-1:0];

endmodule

// ===== sv/ksn_dp.sv =====
// Datapath of the knob cursor navigator: registers, cursor arithmetic and divider.
module ksn_dp
    import ksn_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]            in_opcode,
    input  logic [7:0]            in_pot,
    input  logic [31:0]           in_now,
    input  logic [31:0]           in_hold,
    input  ksn_cmd_t              cmd,
    output ksn_sts_t              sts,
    output logic [7:0]            out_cursor,
    output logic                  out_edge,
    output logic                  out_hold
);

    localparam int TW = TIME_WIDTH;
    localparam int CW = (TW > 16 + QW) ? TW : 16 + QW;

    // Configuration registers.
    logic [7:0]  item_count_reg;
    logic [6:0]  step_thr_reg;
    logic [6:0]  vel_div_reg;
    logic [6:0]  max_step_reg;
    logic [6:0]  edge_zone_reg;
    logic [15:0] rep_delay_reg;
    logic [15:0] rep_tick_reg;

    // Architectural state.
    logic [7:0]        cursor_reg;
    logic [7:0]        anchor_reg;
    logic signed [7:0] acc_reg;
    logic [TW-1:0]     edge_start_reg;
    logic [TW-1:0]     last_upd_reg;
    logic [TW-1:0]     hold_until_reg;

    // Captured item and working registers.
    logic [1:0]    op_reg;
    logic [7:0]    pot_reg;
    logic [TW-1:0] now_reg;
    logic [TW-1:0] holdlen_reg;
    logic [TW-1:0] dwell_reg;
    logic          is_dwell_reg;
    logic          down_reg;
    logic [6:0]    abs_t_reg;
    logic [6:0]    vel_reg;
    logic [13:0]   mag_reg;
    logic [7:0]    out_cursor_reg;
    logic          out_edge_reg;
    logic          out_hold_reg;

    // Effective values: a zero register acts as one.
    logic [7:0]  count_eff;
    logic [7:0]  hi;
    logic [6:0]  thr_eff;
    logic [6:0]  vdiv_eff;
    logic [6:0]  maxs_eff;
    logic [15:0] tick_eff;

    assign count_eff = (item_count_reg == '0) ? 8'd1 : item_count_reg;
    assign hi        = count_eff - 8'd1;
    assign thr_eff   = (step_thr_reg == '0) ? 7'd1 : step_thr_reg;
    assign vdiv_eff  = (vel_div_reg == '0) ? 7'd1 : vel_div_reg;
    assign maxs_eff  = (max_step_reg == '0) ? 7'd1 : max_step_reg;
    assign tick_eff  = (rep_tick_reg == '0) ? 16'd1 : rep_tick_reg;

    // Per-sample delta; jumps of half a turn or more count as no movement.
    logic [8:0]        dv_raw;
    logic              dv_ok;
    logic signed [7:0] dv;
    logic [7:0]        neg_dv;
    logic [6:0]        abs_dv;
    logic signed [8:0] t_sum;
    logic signed [7:0] t_clamp;
    logic [7:0]        neg_t;
    logic [6:0]        abs_t;

    assign dv_raw = {1'b0, pot_reg} - {1'b0, anchor_reg};
    assign dv_ok  = (dv_raw[8:7] == 2'b00) || ((dv_raw[8:7] == 2'b11) && (dv_raw[6:0] != '0));
    assign dv     = dv_ok ? dv_raw[7:0] : 8'sd0;
    assign neg_dv = 8'd0 - dv;
    assign abs_dv = dv[7] ? neg_dv[6:0] : dv[6:0];
    assign t_sum  = {acc_reg[7], acc_reg} + {dv[7], dv};

    always_comb
    begin
        if (t_sum > 9'sd127)
        begin
            t_clamp = 8'sd127;
        end
        else if (t_sum < -9'sd127)
        begin
            t_clamp = -8'sd127;
        end
        else
        begin
            t_clamp = t_sum[7:0];
        end
    end

    assign neg_t = 8'd0 - t_clamp;
    assign abs_t = t_clamp[7] ? neg_t[6:0] : t_clamp[6:0];

    // Edge zone and dwell.
    logic [7:0]    zone8;
    logic          left;
    logic          right;
    logic          edge_hit;
    logic [TW-1:0] dwell_calc;
    logic          upd_hold;
    logic          upd_first;
    logic          es_zero;
    logic [TW-1:0] hold_sum;
    logic [1:0]    eval_res;

    assign zone8      = {1'b0, edge_zone_reg};
    assign left       = pot_reg <= zone8;
    assign right      = pot_reg >= (8'd255 - zone8);
    assign edge_hit   = left || right;
    assign dwell_calc = (now_reg >= edge_start_reg) ? (now_reg - edge_start_reg) : '0;
    assign upd_hold   = hold_until_reg != '0;
    assign upd_first  = last_upd_reg == '0;
    assign es_zero    = edge_start_reg == '0;
    assign hold_sum   = now_reg + holdlen_reg;

    always_comb
    begin
        eval_res = EV_DONE;
        if ((op_reg == OP_UPDATE) && !upd_hold && !upd_first)
        begin
            if (edge_hit && !es_zero)
            begin
                eval_res = EV_DWELL;
            end
            else if (edge_hit && (now_reg != '0))
            begin
                eval_res = EV_DONE;
            end
            else
            begin
                eval_res = EV_TRAVEL;
            end
        end
    end

    // Shared divider and its operand selection.
    logic [TW-1:0]  div_dividend;
    logic [15:0]    div_divisor;
    logic           div_busy;
    logic [QW-1:0]  div_q;
    logic [QW-1:0]  div_rem;

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_VEL:
            begin
                div_dividend = TW'(abs_dv);
                div_divisor  = {9'd0, vdiv_eff};
            end
            DSEL_STEP:
            begin
                div_dividend = TW'(abs_t_reg);
                div_divisor  = {9'd0, thr_eff};
            end
            default:
            begin
                div_dividend = dwell_reg;
                div_divisor  = tick_eff;
            end
        endcase
    end

    ksn_div #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quot     (div_q),
        .rem_lo   (div_rem)
    );

    // Velocity multiplier and repeat step.
    logic [7:0]  q_plus1;
    logic [6:0]  vel_next;
    logic [13:0] dstep_mag;

    assign q_plus1  = {1'b0, div_q} + 8'd1;
    assign vel_next = (q_plus1 > {1'b0, maxs_eff}) ? maxs_eff : q_plus1[6:0];

    always_comb
    begin
        if (div_q == '0)
        begin
            dstep_mag = '0;
        end
        else if (div_q >= maxs_eff)
        begin
            dstep_mag = 14'(maxs_eff);
        end
        else
        begin
            dstep_mag = 14'(q_plus1);
        end
    end

    // Saturating cursor move.
    logic [14:0] up_sum;
    logic [7:0]  up_res;
    logic [7:0]  down_res;
    logic [7:0]  cfg_count;
    logic [7:0]  rem_neg;

    assign up_sum    = {7'd0, cursor_reg} + {1'b0, mag_reg};
    assign up_res    = (up_sum > {7'd0, hi}) ? hi : up_sum[7:0];
    assign down_res  = ({6'd0, cursor_reg} < mag_reg) ? 8'd0 : (cursor_reg - mag_reg[7:0]);
    assign cfg_count = (cfg_wdata[7:0] == '0) ? 8'd1 : cfg_wdata[7:0];
    assign rem_neg   = 8'd0 - {1'b0, div_rem};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= 8'd1;
            step_thr_reg   <= 7'd4;
            vel_div_reg    <= 7'd6;
            max_step_reg   <= 7'd8;
            edge_zone_reg  <= 7'd4;
            rep_delay_reg  <= 16'd400;
            rep_tick_reg   <= 16'd80;
            cursor_reg     <= '0;
            anchor_reg     <= '0;
            acc_reg        <= '0;
            edge_start_reg <= '0;
            last_upd_reg   <= '0;
            hold_until_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ITEM_COUNT:
                begin
                    item_count_reg <= cfg_wdata[7:0];
                    if (cursor_reg >= cfg_count)
                    begin
                        cursor_reg <= cfg_count - 8'd1;
                    end
                end
                REG_START_INDEX:
                begin
                    cursor_reg <= (cfg_wdata[7:0] >= count_eff) ? hi : cfg_wdata[7:0];
                end
                REG_STEP_THRESH:  step_thr_reg  <= cfg_wdata[6:0];
                REG_VEL_DIVISOR:  vel_div_reg   <= cfg_wdata[6:0];
                REG_MAX_STEP:     max_step_reg  <= cfg_wdata[6:0];
                REG_EDGE_ZONE:    edge_zone_reg <= cfg_wdata[6:0];
                REG_REPEAT_DELAY: rep_delay_reg <= cfg_wdata;
                REG_REPEAT_TICK:  rep_tick_reg  <= cfg_wdata;
                default:          ;
            endcase
        end
        else if (cmd.eval)
        begin
            case (op_reg)
                OP_UPDATE:
                begin
                    last_upd_reg <= now_reg;
                    anchor_reg   <= pot_reg;
                    if (upd_hold)
                    begin
                        if (now_reg >= hold_until_reg)
                        begin
                            hold_until_reg <= '0;
                        end
                        acc_reg        <= '0;
                        edge_start_reg <= '0;
                    end
                    else if (upd_first)
                    begin
                        edge_start_reg <= '0;
                    end
                    else
                    begin
                        if (!edge_hit)
                        begin
                            edge_start_reg <= '0;
                        end
                        else if (es_zero)
                        begin
                            edge_start_reg <= now_reg;
                        end
                        if (eval_res == EV_TRAVEL)
                        begin
                            acc_reg <= t_clamp;
                        end
                    end
                end
                OP_REANCHOR:
                begin
                    anchor_reg     <= pot_reg;
                    acc_reg        <= '0;
                    edge_start_reg <= '0;
                    hold_until_reg <= '0;
                end
                OP_HOLD:
                begin
                    anchor_reg     <= pot_reg;
                    acc_reg        <= '0;
                    edge_start_reg <= '0;
                    last_upd_reg   <= now_reg;
                    hold_until_reg <= (holdlen_reg != '0) ? hold_sum : '0;
                end
                default: ;
            endcase
        end
        else if (cmd.mul)
        begin
            // The remainder keeps the sign of the travel.
            acc_reg <= acc_reg[7] ? rem_neg : {1'b0, div_rem};
        end
        else if (cmd.move)
        begin
            cursor_reg <= down_reg ? down_res : up_res;
            if (is_dwell_reg && (mag_reg != '0))
            begin
                acc_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_opcode;
            pot_reg     <= in_pot;
            now_reg     <= TW'(in_now);
            holdlen_reg <= TW'(in_hold);
        end
        if (cmd.eval)
        begin
            dwell_reg    <= dwell_calc;
            down_reg     <= left;
            is_dwell_reg <= eval_res == EV_DWELL;
            abs_t_reg    <= abs_t;
        end
        if (cmd.dchk)
        begin
            mag_reg <= sts.dwell_sat ? 14'(maxs_eff) : '0;
        end
        if (cmd.dstep)
        begin
            mag_reg <= dstep_mag;
        end
        if (cmd.vel)
        begin
            vel_reg <= vel_next;
        end
        if (cmd.mul)
        begin
            mag_reg  <= 14'(div_q) * 14'(vel_reg);
            down_reg <= acc_reg[7];
        end
        if (cmd.out_load)
        begin
            out_cursor_reg <= cursor_reg;
            out_edge_reg   <= edge_start_reg != '0;
            out_hold_reg   <= hold_until_reg != '0;
        end
    end

    assign sts.eval_res  = eval_res;
    assign sts.dwell_go  = dwell_reg >= TW'(rep_delay_reg);
    assign sts.dwell_sat = CW'(dwell_reg) >= CW'({tick_eff, QW'(0)});
    assign sts.div_busy  = div_busy;

    assign out_cursor = out_cursor_reg;
    assign out_edge   = out_edge_reg;
    assign out_hold   = out_hold_reg;

    // The cursor never leaves the menu.
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= hi)
        else $error("cursor beyond last menu entry");

    // Travel stays clamped to plus or minus 127.
    a_acc_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg != -8'sd128)
        else $error("travel accumulator left its clamp range");

    // An auto-repeat move discards accumulated travel.
    a_repeat_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.move && is_dwell_reg && (mag_reg != '0) && !cfg_wr_en) |=> (acc_reg == '0))
        else $error("travel kept after an edge repeat");

endmodule

// ===== sv/ksn_ctrl.sv =====
// Sequencing state machine and stream handshakes of the knob cursor navigator.
module ksn_ctrl
    import ksn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  ksn_sts_t sts,
    output ksn_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_DCHK  = 4'd2;
    localparam logic [3:0] S_DIVT  = 4'd3;
    localparam logic [3:0] S_DSTEP = 4'd4;
    localparam logic [3:0] S_DIVV  = 4'd5;
    localparam logic [3:0] S_VEL   = 4'd6;
    localparam logic [3:0] S_DIVQ  = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_MOVE  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = DSEL_DWELL;
        state_next  = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                case (sts.eval_res)
                    EV_DWELL:
                    begin
                        state_next = S_DCHK;
                    end
                    EV_TRAVEL:
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DSEL_VEL;
                        state_next    = S_DIVV;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_DCHK:
            begin
                cmd.dchk = 1'b1;
                if (!sts.dwell_go)
                begin
                    state_next = S_FIN;
                end
                else if (sts.dwell_sat)
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_DWELL;
                    state_next    = S_DIVT;
                end
            end
            S_DIVT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_DSTEP;
                end
            end
            S_DSTEP:
            begin
                cmd.dstep  = 1'b1;
                state_next = S_MOVE;
            end
            S_DIVV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_VEL;
                end
            end
            S_VEL:
            begin
                cmd.vel       = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_STEP;
                state_next    = S_DIVQ;
            end
            S_DIVQ:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;

    // The divider is only restarted once its previous quotient is complete.
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider restarted while busy");

    // At most one datapath operation per cycle.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.eval, cmd.dchk, cmd.dstep, cmd.vel, cmd.mul, cmd.move,
                  cmd.out_load}))
        else $error("conflicting datapath commands");

    // A finished item always reaches the output register.
    a_result_presented: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && out_free) |=> out_valid_reg)
        else $error("result lost at the output register");

endmodule

// ===== sv/knob_cursor_navigator_top.sv =====
// Top level of the knob cursor navigator: stream ports, configuration port and wiring.
//
// The block turns timestamped potentiometer samples into a menu cursor. Each input
// transaction yields exactly one output transaction carrying the cursor and the
// edge-dwell and hold flags after that item. Items are handled one at a time: a
// re-anchor, a hold, an unused opcode or an update that only seeds state goes from
// evaluation straight to the result; an edge dwell update adds a dwell check and, when
// it repeats, a move, and an ordinary travel update adds two divides, a multiply and a
// move. The shared restoring divider produces one quotient bit per cycle and is used
// twice by a travel update (velocity, then whole steps and remainder), at most once
// by an auto-repeat (dwell ticks). The finished result sits in an output register, so
// the next transaction is accepted while the previous result still waits to be taken.
// Timestamps are held TIME_WIDTH bits wide; now_ms and hold_ms are truncated or
// zero-extended to that width, and hold windows wrap modulo two to that power.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata and must only
// be written while no transaction is in flight. Reset loads the configuration defaults
// and clears the cursor, travel and timing state; no clearing pass is needed.
module knob_cursor_navigator_top
    import ksn_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [71:0]           s_tdata,   // pot_sample[7:0], now_ms[39:8], hold_ms[71:40]
    input  logic [1:0]            s_tuser,   // opcode[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata    // cursor_index[7:0], edge_dwell_active[8],
                                             // hold_active[9], zero[15:10]
);

    ksn_cmd_t   cmd;
    ksn_sts_t   sts;
    logic [7:0] cursor_index;
    logic       edge_dwell_active;
    logic       hold_active;

    // The controller owns both handshakes and sequences the datapath.
    ksn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath captures the item on the load command and holds the result register.
    ksn_dp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_opcode  (s_tuser),
        .in_pot     (s_tdata[7:0]),
        .in_now     (s_tdata[39:8]),
        .in_hold    (s_tdata[71:40]),
        .cmd        (cmd),
        .sts        (sts),
        .out_cursor (cursor_index),
        .out_edge   (edge_dwell_active),
        .out_hold   (hold_active)
    );

    assign m_tdata = {6'd0, hold_active, edge_dwell_active, cursor_index};

endmodule
